// ===== rtl/wino_pkg.sv =====
// shared types and constants for the winograd f(2x2,3x3) tile engine
`timescale 1ns / 1ps

package wino_pkg;

    localparam int MAX_CHANNELS = 64;
    localparam int CH_W         = 6;
    localparam int NUM_PROD     = 16;
    localparam int WGT_W        = 19;
    localparam int XV_W         = 18;
    localparam int PROD_W       = XV_W + WGT_W;
    localparam int ACC_W        = 42;
    localparam int FIFO_DEPTH   = 8;
    localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW      = $clog2(FIFO_DEPTH) + 1;
    localparam int NUM_STAGES   = 6;

    localparam logic       FUNC_WEIGHT = 1'b0;
    localparam logic       FUNC_DATA   = 1'b1;
    localparam logic [1:0] KROW_LAST   = 2'd2;
    localparam logic [1:0] TROW_LAST   = 2'd3;

    localparam logic [1:0] REG_NUM_CHANNELS = 2'd0;
    localparam logic [1:0] REG_BIAS         = 2'd1;
    localparam logic [1:0] REG_RELU_ENABLE  = 2'd2;

    typedef struct packed {
        logic              func;
        logic [CH_W-1:0]   channel;
        logic [1:0]        row;
        logic signed [15:0] v0;
        logic signed [15:0] v1;
        logic signed [15:0] v2;
        logic signed [15:0] v3;
    } in_t;

    typedef struct packed {
        logic signed [15:0] out00;
        logic signed [15:0] out01;
        logic signed [15:0] out10;
        logic signed [15:0] out11;
        logic               saturated;
    } out_t;

    typedef logic [NUM_PROD-1:0][WGT_W-1:0] wrow_t;

    typedef struct packed {
        logic valid;
        logic first;
    } lane_ctl_t;

endpackage

// ===== rtl/wino_lane.sv =====
// one multiply-accumulate lane of the elementwise product stage
`timescale 1ns / 1ps

module wino_lane import wino_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  lane_ctl_t                ctl,
    input  logic signed [XV_W-1:0]   v,
    input  logic signed [WGT_W-1:0]  w,
    output logic signed [ACC_W-1:0]  acc
);

    logic                      p_vld_reg;
    logic                      p_first_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_vld_reg <= 1'b0;
        end else begin
            p_vld_reg <= ctl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        p_first_reg <= ctl.first;
        prod_reg    <= PROD_W'(v) * PROD_W'(w);
        if (p_vld_reg) begin
            acc_reg <= acc_next;
        end
    end

    // channel zero restarts the sum, wraps at the accumulator width
    always_comb begin
        if (p_first_reg) begin
            acc_next = ACC_W'(prod_reg);
        end else begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    assign acc = acc_reg;

endmodule

// ===== rtl/wino_merge.sv =====
// output transform a^t m a, bias, relu and saturation over the lane sums
`timescale 1ns / 1ps

module wino_merge import wino_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    input  logic signed [ACC_W-1:0]  m [NUM_PROD],
    input  logic signed [15:0]       bias,
    input  logic                     relu_enable,
    output logic                     out_valid,
    output out_t                     out_data,
    output logic [2:0]               pend
);

    logic                    va_reg, vb_reg, vc_reg;
    logic signed [43:0]      ta_reg [2][4];
    logic signed [43:0]      ta_next [2][4];
    logic signed [45:0]      ob_reg [4];
    logic signed [45:0]      ob_next [4];
    out_t                    oc_reg;
    out_t                    oc_next;
    logic signed [15:0]      pix [4];
    logic [3:0]              sat;
    logic signed [36:0]      y [4];

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            ta_next[0][j] = 44'(m[j]) + 44'(m[4+j]) + 44'(m[8+j]);
            ta_next[1][j] = 44'(m[4+j]) - 44'(m[8+j]) - 44'(m[12+j]);
        end
        for (int i = 0; i < 2; i++) begin
            ob_next[i*2]   = 46'(ta_reg[i][0]) + 46'(ta_reg[i][1]) + 46'(ta_reg[i][2]);
            ob_next[i*2+1] = 46'(ta_reg[i][1]) - 46'(ta_reg[i][2]) - 46'(ta_reg[i][3]);
        end
    end

    // floor shift back to q8.8, then bias, relu and clip
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            y[k]   = 37'(ob_reg[k] >>> 10) + 37'(bias);
            sat[k] = 1'b0;
            if (relu_enable && y[k] < 0) begin
                y[k] = '0;
            end
            if (y[k] > 37'sd32767) begin
                pix[k] = 16'sh7fff;
                sat[k] = 1'b1;
            end else if (y[k] < -37'sd32768) begin
                pix[k] = 16'sh8000;
                sat[k] = 1'b1;
            end else begin
                pix[k] = y[k][15:0];
            end
        end
        oc_next.out00     = pix[0];
        oc_next.out01     = pix[1];
        oc_next.out10     = pix[2];
        oc_next.out11     = pix[3];
        oc_next.saturated = |sat;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        ta_reg <= ta_next;
        ob_reg <= ob_next;
        oc_reg <= oc_next;
    end

    assign out_valid = vc_reg;
    assign out_data  = oc_reg;
    assign pend      = {va_reg, vb_reg, vc_reg};

endmodule

// ===== rtl/wino_fifo.sv =====
// result queue between the output transform and the result channel
`timescale 1ns / 1ps

module wino_fifo import wino_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wr_en,
    input  out_t               wr_data,
    input  logic               rd_en,
    output out_t               rd_data,
    output logic               not_empty,
    output logic [FIFO_CW-1:0] count
);

    out_t                 mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CW-1:0]   cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (wr_en) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (rd_en && !wr_en) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data   = mem_reg[rd_ptr_reg];
    assign not_empty = (cnt_reg != '0);
    assign count     = cnt_reg;

endmodule

// ===== rtl/winograd_3x3_conv_tile.sv =====
// top level of the winograd f(2x2,3x3) tile engine for one output channel
//
//  channel   ports                          moves
//  input     s_valid s_ready s_data         weight rows and tile rows, one per transfer
//  result    m_valid m_ready m_data         2x2 output tile and saturation flag
//  config    cfg_wr_en cfg_addr cfg_wdata   num_channels, bias, relu_enable
//
//  one input transfer per cycle while s_ready is high, weight rows and tile rows alike
//  a last-channel tile row 3 passes the lane registers and the merge registers to the queue
//  the weight store is one row of 16 transforms per channel, one port each way
//  reset is synchronous active low and clears control state only
//  the result queue holds 8 tiles; s_ready drops only when queue plus tiles in flight fill it
`timescale 1ns / 1ps

module winograd_3x3_conv_tile import wino_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_t         s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_t        m_data,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    // configuration registers
    logic [6:0]          num_channels_reg;
    logic signed [15:0]  bias_reg;
    logic                relu_enable_reg;

    // row buffers
    logic signed [15:0]  kbuf_reg [2][3];
    logic signed [15:0]  tbuf_reg [3][4];

    // weight store, one row of transforms per channel
    wrow_t               wmem [MAX_CHANNELS];
    wrow_t               w_rdata_reg;
    wrow_t               u_next;

    // input transform
    logic signed [15:0]  d [4][4];
    logic signed [16:0]  bt [4][4];
    logic signed [17:0]  v_next [NUM_PROD];
    logic signed [17:0]  v_reg [NUM_PROD];

    // weight transform
    logic signed [15:0]  g [3][3];
    logic signed [17:0]  gt [4][3];
    logic signed [19:0]  u_full [NUM_PROD];

    logic                accept;
    logic                wgt_store;
    logic                tile_done;
    logic                tile_emit;

    logic                s1_vld_reg, s1_first_reg;
    logic                e1_reg, e2_reg, e3_reg;
    lane_ctl_t           lane_ctl;
    logic signed [ACC_W-1:0] acc [NUM_PROD];

    logic                mg_valid;
    out_t                mg_data;
    logic [2:0]          mg_pend;
    logic [NUM_STAGES-1:0] pend;
    logic [FIFO_CW-1:0]  fifo_cnt;
    logic [FIFO_CW-1:0]  occupancy;

    assign accept    = s_valid && s_ready;
    assign wgt_store = accept && s_data.func == FUNC_WEIGHT && s_data.row == KROW_LAST;
    assign tile_done = accept && s_data.func == FUNC_DATA && s_data.row == TROW_LAST;
    assign tile_emit = (7'(s_data.channel) + 7'd1) == num_channels_reg;

    // queue space is reserved for every result tile still in the pipeline
    assign pend      = {e1_reg, e2_reg, e3_reg, mg_pend};
    assign occupancy = fifo_cnt + FIFO_CW'($countones(pend));
    assign s_ready   = occupancy < FIFO_CW'(FIFO_DEPTH);

    // config decode
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_channels_reg <= 7'd1;
            bias_reg         <= '0;
            relu_enable_reg  <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_NUM_CHANNELS: num_channels_reg <= cfg_wdata[6:0];
                REG_BIAS:         bias_reg         <= cfg_wdata;
                REG_RELU_ENABLE:  relu_enable_reg  <= cfg_wdata[0];
                default:          ;
            endcase
        end
    end

    // kernel rows 0 and 1, tile rows 0 to 2
    always_ff @(posedge aclk) begin
        if (accept && s_data.func == FUNC_WEIGHT && s_data.row < KROW_LAST) begin
            kbuf_reg[s_data.row[0]][0] <= s_data.v0;
            kbuf_reg[s_data.row[0]][1] <= s_data.v1;
            kbuf_reg[s_data.row[0]][2] <= s_data.v2;
        end
        if (accept && s_data.func == FUNC_DATA && s_data.row < TROW_LAST) begin
            tbuf_reg[s_data.row][0] <= s_data.v0;
            tbuf_reg[s_data.row][1] <= s_data.v1;
            tbuf_reg[s_data.row][2] <= s_data.v2;
            tbuf_reg[s_data.row][3] <= s_data.v3;
        end
    end

    // g g g^t scaled by 4, clipped to 19 bits
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            g[0][j] = kbuf_reg[0][j];
            g[1][j] = kbuf_reg[1][j];
        end
        g[2][0] = s_data.v0;
        g[2][1] = s_data.v1;
        g[2][2] = s_data.v2;
        for (int j = 0; j < 3; j++) begin
            gt[0][j] = 18'(g[0][j]) <<< 1;
            gt[1][j] = 18'(g[0][j]) + 18'(g[1][j]) + 18'(g[2][j]);
            gt[2][j] = 18'(g[0][j]) - 18'(g[1][j]) + 18'(g[2][j]);
            gt[3][j] = 18'(g[2][j]) <<< 1;
        end
        for (int i = 0; i < 4; i++) begin
            u_full[i*4]   = 20'(gt[i][0]) <<< 1;
            u_full[i*4+1] = 20'(gt[i][0]) + 20'(gt[i][1]) + 20'(gt[i][2]);
            u_full[i*4+2] = 20'(gt[i][0]) - 20'(gt[i][1]) + 20'(gt[i][2]);
            u_full[i*4+3] = 20'(gt[i][2]) <<< 1;
        end
        for (int k = 0; k < NUM_PROD; k++) begin
            if (u_full[k] > 20'sd262143) begin
                u_next[k] = 19'h3ffff;
            end else if (u_full[k] < -20'sd262144) begin
                u_next[k] = 19'h40000;
            end else begin
                u_next[k] = u_full[k][WGT_W-1:0];
            end
        end
    end

    // b^t d b over the three buffered rows and the incoming row
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 4; j++) begin
                d[i][j] = tbuf_reg[i][j];
            end
        end
        d[3][0] = s_data.v0;
        d[3][1] = s_data.v1;
        d[3][2] = s_data.v2;
        d[3][3] = s_data.v3;
        for (int j = 0; j < 4; j++) begin
            bt[0][j] = 17'(d[0][j]) - 17'(d[2][j]);
            bt[1][j] = 17'(d[1][j]) + 17'(d[2][j]);
            bt[2][j] = 17'(d[2][j]) - 17'(d[1][j]);
            bt[3][j] = 17'(d[1][j]) - 17'(d[3][j]);
        end
        for (int i = 0; i < 4; i++) begin
            v_next[i*4]   = 18'(bt[i][0]) - 18'(bt[i][2]);
            v_next[i*4+1] = 18'(bt[i][1]) + 18'(bt[i][2]);
            v_next[i*4+2] = 18'(bt[i][2]) - 18'(bt[i][1]);
            v_next[i*4+3] = 18'(bt[i][1]) - 18'(bt[i][3]);
        end
    end

    // weight store: write on kernel row 2, read on tile row 3
    always_ff @(posedge aclk) begin
        if (wgt_store) begin
            wmem[s_data.channel] <= u_next;
        end
        if (tile_done) begin
            w_rdata_reg <= wmem[s_data.channel];
        end
    end

    always_ff @(posedge aclk) begin
        if (tile_done) begin
            v_reg <= v_next;
        end
        s1_first_reg <= (s_data.channel == '0);
    end

    // pipeline control: s1 transform, lane product, lane sum
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            e1_reg     <= 1'b0;
            e2_reg     <= 1'b0;
            e3_reg     <= 1'b0;
        end else begin
            s1_vld_reg <= tile_done;
            e1_reg     <= tile_done && tile_emit;
            e2_reg     <= e1_reg;
            e3_reg     <= e2_reg;
        end
    end

    assign lane_ctl.valid = s1_vld_reg;
    assign lane_ctl.first = s1_first_reg;

    for (genvar k = 0; k < NUM_PROD; k++) begin : g_lane
        wino_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (lane_ctl),
            .v       (v_reg[k]),
            .w       (w_rdata_reg[k]),
            .acc     (acc[k])
        );
    end

    wino_merge u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (e3_reg),
        .m           (acc),
        .bias        (bias_reg),
        .relu_enable (relu_enable_reg),
        .out_valid   (mg_valid),
        .out_data    (mg_data),
        .pend        (mg_pend)
    );

    wino_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (mg_valid),
        .wr_data   (mg_data),
        .rd_en     (m_valid && m_ready),
        .rd_data   (m_data),
        .not_empty (m_valid),
        .count     (fifo_cnt)
    );

    // queue plus tiles in flight never exceed the queue depth
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(fifo_cnt) + $countones(pend)) <= FIFO_DEPTH)
        else $error("result queue overcommitted");

    // a last-channel tile enters the result pipeline
    a_emit_tracked: assert property (@(posedge aclk) disable iff (!aresetn)
        (tile_done && tile_emit) |=> e1_reg)
        else $error("result tile lost at entry");

    // a result tile passes from e1 through e2 to e3, the output transform input
    a_emit_reaches_merge: assert property (@(posedge aclk) disable iff (!aresetn)
        e1_reg |=> ##1 e3_reg)
        else $error("result tile lost in lanes");

endmodule
